[sv/sswe_pkg.sv]
// Shared constants, codes and types of the scalar to sparse window encoder.
package sswe_pkg;

   localparam int NUM_BITS      = 1024;
   localparam int VALUE_BITS    = 32;
   localparam int WORD_BITS     = 64;
   localparam int NUM_WORDS     = (NUM_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WIDX_BITS     = $clog2(NUM_WORDS);
   localparam int BIT_SEL_BITS  = $clog2(WORD_BITS);
   localparam int POS_BITS      = $clog2(NUM_BITS + 1);
   localparam int QUOT_BITS     = $clog2(NUM_BITS);
   localparam int NUMER_BITS    = QUOT_BITS + VALUE_BITS;
   localparam int DIV_CNT_BITS  = $clog2(QUOT_BITS + 1);
   localparam int CFG_CNT_BITS  = 11;
   localparam int CSR_IDX_BITS  = 2;
   localparam int RSP_RAW_BITS  = WIDX_BITS + WORD_BITS;
   localparam int RSP_DATA_BITS = ((RSP_RAW_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - RSP_RAW_BITS;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_MIN_VALUE   = 2'd0,
      REG_MAX_VALUE   = 2'd1,
      REG_TOTAL_BITS  = 2'd2,
      REG_ACTIVE_BITS = 2'd3
   } reg_index_type;

   typedef enum logic {
      CMD_ENCODE = 1'b0,
      CMD_CLEAR  = 1'b1
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_OFFS,
      ST_MUL,
      ST_DIVGO,
      ST_DIV,
      ST_WIN,
      ST_CMP,
      ST_EMIT,
      ST_BAD
   } state_type;

   typedef struct packed {
      logic                 clear;
      logic                 rd_en;
      logic [WIDX_BITS-1:0] rd_idx;
      logic                 wr_en;
      logic [WIDX_BITS-1:0] wr_idx;
      logic [WORD_BITS-1:0] wr_data;
   } store_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [QUOT_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

[sv/sswe_divider.sv]
// Iterative restoring divider that yields the window start, one quotient bit a cycle.
module sswe_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [sswe_pkg::NUMER_BITS-1:0]   numerator,
   input  logic [sswe_pkg::VALUE_BITS-1:0]   divisor,
   output sswe_pkg::div_rsp_type             result
);
   import sswe_pkg::*;

   logic [VALUE_BITS-1:0]   rem_ff, rem_in;
   logic [QUOT_BITS-1:0]    low_ff, low_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    done_ff, done_in;
   logic [VALUE_BITS:0]     trial;
   logic [VALUE_BITS:0]     diff;
   logic                    fits;

   // The quotient is known to stay below 2**QUOT_BITS, so the upper numerator
   // bits are already a valid partial remainder.
   always_comb begin
      trial   = {rem_ff, low_ff[QUOT_BITS-1]};
      diff    = trial - {1'b0, divisor};
      fits    = trial >= {1'b0, divisor};
      rem_in  = rem_ff;
      low_in  = low_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = numerator[NUMER_BITS-1:QUOT_BITS];
         low_in = numerator[QUOT_BITS-1:0];
         cnt_in = DIV_CNT_BITS'(QUOT_BITS);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
         low_in  = {low_ff[QUOT_BITS-2:0], fits};
         cnt_in  = cnt_ff - DIV_CNT_BITS'(1);
         done_in = (cnt_ff == DIV_CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
   end

   assign result.done     = done_ff;
   assign result.quotient = low_ff;

endmodule

[sv/sswe_pattern_store.sv]
// Store of the previous pattern: word memory with per-word valid bits.
module sswe_pattern_store (
   input  logic                            clock,
   input  logic                            reset,
   input  sswe_pkg::store_cmd_type         cmd,
   output logic [sswe_pkg::WORD_BITS-1:0]  rd_data
);
   import sswe_pkg::*;

   logic [WORD_BITS-1:0] mem [NUM_WORDS];
   logic [NUM_WORDS-1:0] valid_ff, valid_in;
   logic [WORD_BITS-1:0] rd_data_ff;

   // An entry that is not valid reads as zero.
   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear) begin
         valid_in = '0;
      end else if (cmd.wr_en) begin
         valid_in[cmd.wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_idx] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= valid_ff[cmd.rd_idx] ? mem[cmd.rd_idx] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/scalar_to_sparse_window_encoder_core.sv]
// Top level: sequencer, configuration registers and result register of the window encoder.
// An encode request runs the check, offset, multiply and divide steps, then a compare pass over
// every store word and the emission of one word per 64 bits of the saturated pattern length;
// with equal bounds the 10-step divider is skipped. Result back-pressure stalls the emission.
// A clear is taken in the idle state; a bad configuration gives a single flagged result.
// Reset (synchronous, active high) loads the register defaults and marks the store empty.
module scalar_to_sparse_window_encoder_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [sswe_pkg::VALUE_BITS-1:0]       req_tdata,   // [31:0] value
   input  logic                                  req_tuser,   // [0] cmd
   // result channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [sswe_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,   // [3:0] word_index, [67:4] pattern_word
   output logic                                  rsp_tlast,
   output logic [1:0]                            rsp_tuser,   // [0] changed, [1] config_bad
   // configuration write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sswe_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [sswe_pkg::VALUE_BITS-1:0]       csr_data
);
   import sswe_pkg::*;

   // Configuration registers.
   logic signed [VALUE_BITS-1:0] min_ff, max_ff;
   logic [CFG_CNT_BITS-1:0]      total_ff, active_ff;

   // Sequencer and datapath registers.
   state_type                    state_ff, state_in;
   logic signed [VALUE_BITS-1:0] value_ff, value_in;
   logic signed [VALUE_BITS-1:0] cv_ff, cv_in;
   logic [VALUE_BITS-1:0]        off_ff, off_in;
   logic [VALUE_BITS-1:0]        span_ff, span_in;
   logic [QUOT_BITS-1:0]         diff_ff, diff_in;
   logic [NUMER_BITS-1:0]        prod_ff, prod_in;
   logic [POS_BITS-1:0]          start_ff, start_in;
   logic [POS_BITS-1:0]          end_ff, end_in;
   logic [WIDX_BITS-1:0]         last_idx_ff, last_idx_in;
   logic                         chg_ff, chg_in;
   logic [WIDX_BITS:0]           cnt_ff, cnt_in;

   // Result register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [WIDX_BITS-1:0]         rsp_idx_ff, rsp_idx_in;
   logic [WORD_BITS-1:0]         rsp_word_ff, rsp_word_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic                         rsp_chg_ff, rsp_chg_in;
   logic                         rsp_bad_ff, rsp_bad_in;

   logic [POS_BITS-1:0]          total_eff;
   logic                         cfg_bad;
   logic                         out_free;
   logic [WIDX_BITS:0]           cnt_dec;
   logic [WIDX_BITS-1:0]         gen_idx;
   logic [WORD_BITS-1:0]         gen_word;
   logic                         div_start;
   div_rsp_type                  div_rsp;
   store_cmd_type                store_cmd;
   logic [WORD_BITS-1:0]         store_rd;

   // One 64-bit word of the window [lo, hi).
   function automatic logic [WORD_BITS-1:0] window_word(
      input logic [WIDX_BITS-1:0] idx,
      input logic [POS_BITS-1:0]  lo,
      input logic [POS_BITS-1:0]  hi
   );
      logic [WORD_BITS-1:0] w;
      logic [POS_BITS-1:0]  b;
      for (int j = 0; j < WORD_BITS; j++) begin
         b    = POS_BITS'({idx, BIT_SEL_BITS'(j)});
         w[j] = (b >= lo) && (b < hi);
      end
      return w;
   endfunction

   sswe_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (prod_ff),
      .divisor   (span_ff),
      .result    (div_rsp)
   );

   sswe_pattern_store u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (store_cmd),
      .rd_data (store_rd)
   );

   // Saturate the pattern length to the store capacity.
   assign total_eff = (32'(total_ff) > 32'(NUM_BITS)) ? POS_BITS'(NUM_BITS)
                                                      : POS_BITS'(total_ff);
   assign cfg_bad   = (min_ff > max_ff) || (total_eff == '0) || (active_ff == '0) ||
                      (32'(active_ff) > 32'(total_eff));

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // The compare pass writes one word behind the read address; emission uses the count.
   assign cnt_dec  = cnt_ff - (WIDX_BITS + 1)'(1);
   assign gen_idx  = (state_ff == ST_CMP) ? cnt_dec[WIDX_BITS-1:0] : cnt_ff[WIDX_BITS-1:0];
   assign gen_word = window_word(gen_idx, start_ff, end_ff);

   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      cv_in        = cv_ff;
      off_in       = off_ff;
      span_in      = span_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      last_idx_in  = last_idx_ff;
      chg_in       = chg_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_chg_in   = rsp_chg_ff;
      rsp_bad_in   = rsp_bad_ff;
      div_start    = 1'b0;
      store_cmd    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (cmd_type'(req_tuser) == CMD_CLEAR) begin
                  // Drop the stored pattern; a clear request has no result.
                  store_cmd.clear = 1'b1;
               end else begin
                  value_in = req_tdata;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (cfg_bad) begin
               state_in = ST_BAD;
            end else begin
               cv_in       = (value_ff < min_ff) ? min_ff :
                             (value_ff > max_ff) ? max_ff : value_ff;
               diff_in     = QUOT_BITS'(total_eff - POS_BITS'(active_ff));
               last_idx_in = WIDX_BITS'((total_eff - POS_BITS'(1)) >> BIT_SEL_BITS);
               state_in    = ST_OFFS;
            end
         end
         ST_OFFS: begin
            // Both differences are non-negative and below 2**32.
            off_in   = cv_ff - min_ff;
            span_in  = max_ff - min_ff;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = NUMER_BITS'(diff_ff) * NUMER_BITS'(off_ff);
            state_in = ST_DIVGO;
         end
         ST_DIVGO: begin
            if (span_ff == '0) begin
               start_in = '0;
               state_in = ST_WIN;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               start_in = POS_BITS'(div_rsp.quotient);
               state_in = ST_WIN;
            end
         end
         ST_WIN: begin
            end_in   = start_ff + POS_BITS'(active_ff);
            cnt_in   = '0;
            chg_in   = 1'b0;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // Read word cnt, compare and overwrite word cnt-1.
            store_cmd.rd_en  = (cnt_ff < (WIDX_BITS + 1)'(NUM_WORDS));
            store_cmd.rd_idx = cnt_ff[WIDX_BITS-1:0];
            if (cnt_ff != '0) begin
               store_cmd.wr_en   = 1'b1;
               store_cmd.wr_idx  = cnt_dec[WIDX_BITS-1:0];
               store_cmd.wr_data = gen_word;
               if (gen_word != store_rd) begin
                  chg_in = 1'b1;
               end
            end
            if (cnt_ff == (WIDX_BITS + 1)'(NUM_WORDS)) begin
               cnt_in   = '0;
               state_in = ST_EMIT;
            end else begin
               cnt_in = cnt_ff + (WIDX_BITS + 1)'(1);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = cnt_ff[WIDX_BITS-1:0];
               rsp_word_in  = gen_word;
               rsp_last_in  = (cnt_ff[WIDX_BITS-1:0] == last_idx_ff);
               rsp_chg_in   = (cnt_ff[WIDX_BITS-1:0] == last_idx_ff) && chg_ff;
               rsp_bad_in   = 1'b0;
               if (cnt_ff[WIDX_BITS-1:0] == last_idx_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + (WIDX_BITS + 1)'(1);
               end
            end
         end
         ST_BAD: begin
            // Single flagged result; leave the store alone.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = '0;
               rsp_word_in  = '0;
               rsp_last_in  = 1'b1;
               rsp_chg_in   = 1'b0;
               rsp_bad_in   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff    <= '0;
         max_ff    <= VALUE_BITS'(65535);
         total_ff  <= CFG_CNT_BITS'(1024);
         active_ff <= CFG_CNT_BITS'(32);
      end else if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_MIN_VALUE:   min_ff    <= csr_data;
            REG_MAX_VALUE:   max_ff    <= csr_data;
            REG_TOTAL_BITS:  total_ff  <= csr_data[CFG_CNT_BITS-1:0];
            REG_ACTIVE_BITS: active_ff <= csr_data[CFG_CNT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      cv_ff       <= cv_in;
      off_ff      <= off_in;
      span_ff     <= span_in;
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
      start_ff    <= start_in;
      end_ff      <= end_in;
      last_idx_ff <= last_idx_in;
      chg_ff      <= chg_in;
      cnt_ff      <= cnt_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
      rsp_chg_ff  <= rsp_chg_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_BITS{1'b0}}, rsp_word_ff, rsp_idx_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_bad_ff, rsp_chg_ff};

   // A flagged result is a lone empty word.
   a_bad_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bad_ff |-> rsp_last_ff && (rsp_idx_ff == '0) && (rsp_word_ff == '0))
      else $error("config_bad result is not a single empty word");

   a_chg_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_chg_ff |-> rsp_last_ff)
      else $error("changed flag set on a word that is not last");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide step");

   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (cnt_ff[WIDX_BITS-1:0] <= last_idx_ff) && !cnt_ff[WIDX_BITS])
      else $error("emitted word index beyond the pattern length");

   a_window_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (end_ff <= total_eff) && (start_ff < end_ff))
      else $error("window runs past the pattern length");

endmodule
